// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the block transposition cipher RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every rising clock edge outside reset.
`define BTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("block transposition cipher: property violated");
// A condition that must never be seen outside reset.
`define BTC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("block transposition cipher: forbidden condition seen");
`else
`define BTC_ASSERT(lbl, clk, rst_n, prop)
`define BTC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/btc_pkg.sv =====
package btc_pkg;

    localparam int MAX_KEY_LEN_DEF = 16;
    // Largest block length the key map can describe.
    localparam int MAX_KEY_LEN_TOP = 16;

    localparam int CHAR_W    = 8;
    localparam int LEN_REG_W = 5;
    localparam int KEY_W     = 4;
    localparam int KEY_MAP_W = 64;
    localparam int CNT_W     = $clog2(MAX_KEY_LEN_TOP + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MAP   = 2'd2;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [CHAR_W-1:0]    PAD_CHAR      = 8'h5F;
    localparam logic                 RST_DIRECTION = DIR_ENCRYPT;
    localparam logic [LEN_REG_W-1:0] RST_BLOCK_LEN = 5'd1;
    localparam logic [KEY_MAP_W-1:0] RST_KEY_MAP   = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_EMIT,
        ST_NONE
    } t_back_state;

    // Descriptor of a completed block: bytes held and end-of-text flag.
    typedef struct packed {
        logic             last;
        logic [CNT_W-1:0] n;
    } t_blk_desc;

    // Oldest queued block as seen by the back end.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [CNT_W-1:0] n;
    } t_blk_head;

    function automatic logic [KEY_W-1:0] key_at(input logic [KEY_MAP_W-1:0] km,
                                                input logic [KEY_W-1:0]     j);
        key_at = km[KEY_W*j +: KEY_W];
    endfunction

endpackage

// ===== rtl/block_transposition_cipher_unit.sv =====
// Block transposition cipher. Text bytes are transferred in on push/full with
// i_text_end marking the last byte; transformed bytes are transferred out on
// empty/pop, the oldest on o_out_char while empty is low. o_run_last flags the
// final result of a text, and o_no_char flags a lone marker result when the
// closing block yields no byte. Registers are written on i_cfg_we; the user
// must write them only while idle, since the block does not enforce it.
// A front end gathers bytes into one of two block banks and queues a block
// descriptor when block_len bytes or the end marker arrive. The back end
// works a block in two passes: it builds the permuted block one position per
// cycle, frees the bank, then sends one byte per cycle into a single output
// register while the receiver keeps that register free. It starts a new
// block only once the last byte of the previous one is in the register.
// While the back end works, the front end fills the other bank; full rises
// only when both banks hold unprocessed blocks. If the receiver stalls, the
// output register holds its result and the back end waits, then the queue
// fills and full stops input. Reset empties the queue and the output, clears
// the byte count and restores encrypt mode, block length one and an identity
// key. There is no clearing pass after reset.
module block_transposition_cipher_unit import btc_pkg::*; #(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_text_end,
    output logic                 empty,
    input  logic                 pop,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_run_last,
    output logic                 o_no_char,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_MAP_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_KEY_LEN);

    logic                 r_dir;
    logic [LEN_REG_W-1:0] r_block_len;
    logic [KEY_MAP_W-1:0] r_key_map;
    logic [CNT_W-1:0]     len_eff;

    logic              wr_en, desc_push, blk_pop, q_full;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [CHAR_W-1:0] wr_data, rd_data;
    t_blk_desc         desc;
    t_blk_head         head;

    // Configuration registers. Unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= RST_DIRECTION;
            r_block_len <= RST_BLOCK_LEN;
            r_key_map   <= RST_KEY_MAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION: r_dir       <= i_cfg_data[0];
                CFG_BLOCK_LEN: r_block_len <= i_cfg_data[LEN_REG_W-1:0];
                CFG_KEY_MAP:   r_key_map   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A block length of zero acts as one; lengths beyond the key size are
    // clamped to it.
    always_comb begin
        if (r_block_len == '0) begin
            len_eff = CNT_W'(1);
        end else if (r_block_len > LEN_REG_W'(MAX_KEY_LEN)) begin
            len_eff = CNT_W'(MAX_KEY_LEN);
        end else begin
            len_eff = CNT_W'(r_block_len);
        end
    end

    assign full = q_full;

    btc_front #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_char   (i_in_char),
        .i_text_end  (i_text_end),
        .i_len       (len_eff),
        .i_q_full    (q_full),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_desc_push (desc_push),
        .o_desc      (desc)
    );

    btc_blkq #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_blkq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_desc_push (desc_push),
        .i_desc      (desc),
        .i_pop       (blk_pop),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data),
        .o_head      (head),
        .o_full      (q_full)
    );

    btc_back #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dir      (r_dir),
        .i_len      (len_eff),
        .i_key_map  (r_key_map),
        .i_head     (head),
        .i_rd_data  (rd_data),
        .i_pop      (pop),
        .o_rd_addr  (rd_addr),
        .o_blk_pop  (blk_pop),
        .o_empty    (empty),
        .o_out_char (o_out_char),
        .o_run_last (o_run_last),
        .o_no_char  (o_no_char)
    );

endmodule

// ===== rtl/btc_front.sv =====
module btc_front import btc_pkg::*; #(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [CHAR_W-1:0]  i_in_char,
    input  logic               i_text_end,
    input  logic [CNT_W-1:0]   i_len,
    input  logic               i_q_full,
    output logic               o_wr_en,
    output logic [$clog2(MAX_KEY_LEN)-1:0] o_wr_addr,
    output logic [CHAR_W-1:0]  o_wr_data,
    output logic               o_desc_push,
    output t_blk_desc          o_desc
);

    localparam int IW = $clog2(MAX_KEY_LEN);

    logic [CNT_W-1:0] r_fill, n_fill, fill_inc;
    logic             accept, room, done;

    assign accept   = i_push && !i_q_full;
    assign room     = (r_fill < CNT_W'(MAX_KEY_LEN));
    assign fill_inc = room ? r_fill + 1'b1 : r_fill;
    // A block closes on the end marker or once it holds block_len bytes.
    assign done     = i_text_end || (fill_inc >= i_len);

    assign o_wr_en     = accept && room;
    assign o_wr_addr   = r_fill[IW-1:0];
    assign o_wr_data   = i_in_char;
    assign o_desc_push = accept && done;
    assign o_desc.last = i_text_end;
    assign o_desc.n    = (fill_inc < i_len) ? fill_inc : i_len;

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            n_fill = done ? '0 : fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

// ===== rtl/btc_blkq.sv =====
`include "assert_macros.svh"

module btc_blkq import btc_pkg::*; #(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [$clog2(MAX_KEY_LEN)-1:0] i_wr_addr,
    input  logic [CHAR_W-1:0]  i_wr_data,
    input  logic               i_desc_push,
    input  t_blk_desc          i_desc,
    input  logic               i_pop,
    input  logic [$clog2(MAX_KEY_LEN)-1:0] i_rd_addr,
    output logic [CHAR_W-1:0]  o_rd_data,
    output t_blk_head          o_head,
    output logic               o_full
);

    // Two banks: the front fills one while the back reads the other.
    localparam int NBANK = 2;
    localparam int QCW   = $clog2(NBANK + 1);

    logic [CHAR_W-1:0] r_mem [NBANK][MAX_KEY_LEN];
    logic [CHAR_W-1:0] r_rd_data;
    t_blk_desc         r_desc [NBANK];
    logic              r_wr_bank, r_rd_bank;
    logic [QCW-1:0]    r_count;

    // The read address is sent ahead of need, so read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_bank][i_wr_addr] <= i_wr_data;
        end
        if (i_desc_push) begin
            r_desc[r_wr_bank] <= i_desc;
        end
        r_rd_data <= r_mem[r_rd_bank][i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_bank <= 1'b0;
            r_rd_bank <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_desc_push) begin
                r_wr_bank <= ~r_wr_bank;
            end
            if (i_pop) begin
                r_rd_bank <= ~r_rd_bank;
            end
            if (i_desc_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_desc_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full      = (r_count == QCW'(NBANK));
    assign o_head.valid = (r_count != '0);
    assign o_head.last  = r_desc[r_rd_bank].last;
    assign o_head.n     = r_desc[r_rd_bank].n;
    assign o_rd_data    = r_rd_data;

    `BTC_ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, i_desc_push && o_full)
    `BTC_ASSERT_NEVER(a_write_when_full, i_clk, i_rst_n, i_wr_en && o_full)
    `BTC_ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, i_pop && !o_head.valid)

endmodule

// ===== rtl/btc_back.sv =====
`include "assert_macros.svh"

module btc_back import btc_pkg::*; #(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_dir,
    input  logic [CNT_W-1:0]     i_len,
    input  logic [KEY_MAP_W-1:0] i_key_map,
    input  t_blk_head            i_head,
    input  logic [CHAR_W-1:0]    i_rd_data,
    input  logic                 i_pop,
    output logic [$clog2(MAX_KEY_LEN)-1:0] o_rd_addr,
    output logic                 o_blk_pop,
    output logic                 o_empty,
    output logic [CHAR_W-1:0]    o_out_char,
    output logic                 o_run_last,
    output logic                 o_no_char
);

    localparam int IW   = $clog2(MAX_KEY_LEN);
    localparam int CMPW = (CNT_W > KEY_W) ? CNT_W : KEY_W;

    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_pos, n_pos, r_keep, n_keep, r_cnt, n_cnt, r_emit, n_emit;
    logic [CNT_W-1:0]  emit_inc, pos_inc, final_cnt, rd_pos;
    logic              r_last, n_last;
    logic [CHAR_W-1:0] r_tmp [MAX_KEY_LEN];
    logic              tmp_we, ld_char, ld_zero;
    logic              r_ov, n_ov, r_olast, n_olast, r_onone, n_onone;
    logic [CHAR_W-1:0] r_ochar;
    logic [KEY_W-1:0]  pos_key, rd_key, jsel;
    logic              found, r_found, pos_valid, at_end, out_free;
    logic [CHAR_W-1:0] pos_byte;

    // Work out the byte of the current block position. Encrypt gathers the
    // byte the key names; decrypt finds the last held byte keyed to here.
    // The bank address is looked up for the next position, so the bank data
    // and the decrypt match flag line up with r_pos in the cycle after.
    always_comb begin
        rd_pos  = (r_state == ST_BUILD) ? pos_inc : '0;
        pos_key = key_at(i_key_map, KEY_W'(r_pos));
        rd_key  = key_at(i_key_map, KEY_W'(rd_pos));
        found   = 1'b0;
        jsel    = '0;
        for (int j = 0; j < MAX_KEY_LEN; j++) begin
            if ((CNT_W'(j) < i_head.n) &&
                (CMPW'(key_at(i_key_map, KEY_W'(j))) == CMPW'(rd_pos))) begin
                found = 1'b1;
                jsel  = KEY_W'(j);
            end
        end
        if (i_dir == DIR_DECRYPT) begin
            pos_valid = r_found;
            o_rd_addr = IW'(jsel);
            pos_byte  = i_rd_data;
        end else begin
            pos_valid = 1'b1;
            o_rd_addr = IW'(rd_key);
            pos_byte  = (CMPW'(pos_key) < CMPW'(i_head.n)) ? i_rd_data : PAD_CHAR;
        end
    end

    assign pos_inc   = r_pos + 1'b1;
    assign emit_inc  = r_emit + 1'b1;
    assign at_end    = (r_pos == i_len) || !pos_valid;
    // On the last decrypted block, trailing pad bytes are cut off.
    assign final_cnt = ((i_dir == DIR_DECRYPT) && i_head.last) ? r_keep : r_pos;
    assign out_free  = !r_ov || i_pop;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_keep    = r_keep;
        n_cnt     = r_cnt;
        n_emit    = r_emit;
        n_last    = r_last;
        n_ov      = r_ov && !i_pop;
        n_olast   = r_olast;
        n_onone   = r_onone;
        tmp_we    = 1'b0;
        ld_char   = 1'b0;
        ld_zero   = 1'b0;
        o_blk_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = ST_BUILD;
                    n_pos   = '0;
                    n_keep  = '0;
                end
            end
            ST_BUILD: begin
                if (at_end) begin
                    o_blk_pop = 1'b1;
                    n_last    = i_head.last;
                    n_cnt     = final_cnt;
                    n_emit    = '0;
                    if (final_cnt != '0) begin
                        n_state = ST_EMIT;
                    end else if (i_head.last) begin
                        n_state = ST_NONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    tmp_we = 1'b1;
                    n_pos  = pos_inc;
                    if (pos_byte != PAD_CHAR) begin
                        n_keep = pos_inc;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    ld_char = 1'b1;
                    n_olast = r_last && (emit_inc == r_cnt);
                    n_onone = 1'b0;
                    if (emit_inc == r_cnt) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit = emit_inc;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    ld_zero = 1'b1;
                    n_olast = 1'b1;
                    n_onone = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_keep  <= n_keep;
        r_cnt   <= n_cnt;
        r_emit  <= n_emit;
        r_last  <= n_last;
        r_olast <= n_olast;
        r_onone <= n_onone;
        r_found <= found;
        if (tmp_we) begin
            r_tmp[r_pos[IW-1:0]] <= pos_byte;
        end
        if (ld_char) begin
            r_ochar <= r_tmp[r_emit[IW-1:0]];
        end else if (ld_zero) begin
            r_ochar <= '0;
        end
    end

    assign o_empty    = !r_ov;
    assign o_out_char = r_ochar;
    assign o_run_last = r_olast;
    assign o_no_char  = r_onone;

    `BTC_ASSERT(a_build_has_block, i_clk, i_rst_n, (r_state == ST_BUILD) |-> i_head.valid)
    `BTC_ASSERT(a_emit_in_range, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (r_emit < r_cnt))
    `BTC_ASSERT(a_out_held, i_clk, i_rst_n, (!o_empty && !i_pop) |=> $stable(o_out_char))

endmodule
